// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the primitive expander. They expand to
// nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Implication checked outside reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");
// Next-cycle implication, also checked during reset
`define ASSERT_NXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, ante, cons)
`endif

`endif

// ===== rtl/core/stlpe_pkg.sv =====
// ----------------------------------------------------------------------------
// stlpe_pkg
// Shared types and codes for the strip-to-list primitive expander.
// ----------------------------------------------------------------------------
package stlpe_pkg;

  // Strip kind as carried on the op field
  typedef enum logic {
    OP_LINE_STRIP = 1'b0,
    OP_TRI_STRIP  = 1'b1
  } strip_op_t;

  // Primitive kind as carried on prim_kind
  typedef enum logic {
    PRIM_LINE = 1'b0,
    PRIM_TRI  = 1'b1
  } prim_kind_t;

  // Depth of the primitive queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Saturation point of the per-strip vertex count
  localparam logic [1:0] SEEN_FULL = 2'd2;

  // Header of one queued primitive
  typedef struct packed {
    prim_kind_t kind;
  } prim_hdr_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/core/stlpe_if.sv =====
// ----------------------------------------------------------------------------
// stlpe_in_if / stlpe_out_if
// Valid/ready channels for strip vertices in and primitive indices out.
// ----------------------------------------------------------------------------
interface stlpe_in_if #(
  parameter int INDEX_BITS = 16
) ();
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic                  strip_start;
  logic [INDEX_BITS-1:0] vertex_index;
  logic [INDEX_BITS-1:0] index_base;

  modport source (output valid, op, strip_start, vertex_index, index_base, input ready);
  modport sink   (input valid, op, strip_start, vertex_index, index_base, output ready);
endinterface

interface stlpe_out_if #(
  parameter int INDEX_BITS = 16
) ();
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] out_index;
  logic                  prim_end;
  logic                  prim_kind;

  modport source (output valid, out_index, prim_end, prim_kind, input ready);
  modport sink   (input valid, out_index, prim_end, prim_kind, output ready);
endinterface

// ===== rtl/core/stlpe_front.sv =====
// ----------------------------------------------------------------------------
// stlpe_front
// Accept strip vertices, rebase them, track strip state and classify each
// vertex into a line segment, a triangle or nothing.
// ----------------------------------------------------------------------------
module stlpe_front #(
  parameter int INDEX_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  stlpe_in_if.sink                    in_chan,
  input  stlpe_pkg::q_stat_t          q_stat,
  output logic                        push,
  output stlpe_pkg::prim_hdr_t        push_hdr,
  output logic [3*INDEX_BITS-1:0]     push_idx
);
  import stlpe_pkg::*;

  logic [INDEX_BITS-1:0] older_r, older_nxt;
  logic [INDEX_BITS-1:0] newer_r, newer_nxt;
  logic [1:0]            seen_r, seen_nxt;
  logic                  parity_r, parity_nxt;
  strip_op_t             kind_r, kind_nxt;

  logic                  accept;
  logic [INDEX_BITS-1:0] v;
  logic [1:0]            seen_eff;
  logic                  parity_eff;
  strip_op_t             kind_eff;
  logic                  emit;

  // Take a request whenever the queue has room
  assign in_chan.ready = !q_stat.full;
  assign accept        = in_chan.valid && in_chan.ready;

  // Rebase, wrapping at the index width
  assign v = in_chan.vertex_index + in_chan.index_base;

  // Strip start restarts count, parity and kind
  always_comb begin
    seen_eff   = in_chan.strip_start ? 2'd0 : seen_r;
    parity_eff = in_chan.strip_start ? 1'b0 : parity_r;
    kind_eff   = in_chan.strip_start ? strip_op_t'(in_chan.op) : kind_r;
  end

  // Classify and order the primitive
  always_comb begin
    emit       = 1'b0;
    push_hdr   = '{kind: PRIM_LINE};
    push_idx   = '0;
    parity_nxt = parity_eff;
    if (kind_eff == OP_LINE_STRIP) begin
      emit     = (seen_eff != 2'd0) && (newer_r != v);
      push_idx = {{INDEX_BITS{1'b0}}, v, newer_r};
    end else begin
      push_hdr = '{kind: PRIM_TRI};
      if (seen_eff == SEEN_FULL) begin
        emit       = (older_r != newer_r) && (newer_r != v) && (older_r != v);
        parity_nxt = !parity_eff;
      end
      if (parity_eff) begin
        push_idx = {v, older_r, newer_r};
      end else begin
        push_idx = {v, newer_r, older_r};
      end
    end
  end

  assign push = accept && emit;

  // Advance the vertex history
  always_comb begin
    older_nxt = newer_r;
    newer_nxt = v;
    seen_nxt  = (seen_eff == SEEN_FULL) ? seen_eff : seen_eff + 2'd1;
    kind_nxt  = kind_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r  <= '0;
      newer_r  <= '0;
      seen_r   <= '0;
      parity_r <= 1'b0;
      kind_r   <= OP_LINE_STRIP;
    end else if (accept) begin
      older_r  <= older_nxt;
      newer_r  <= newer_nxt;
      seen_r   <= seen_nxt;
      parity_r <= parity_nxt;
      kind_r   <= kind_nxt;
    end
  end

endmodule

// ===== rtl/core/stlpe_prim_queue.sv =====
// ----------------------------------------------------------------------------
// stlpe_prim_queue
// Short register queue of classified primitives between front and back.
// ----------------------------------------------------------------------------
module stlpe_prim_queue #(
  parameter int INDEX_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  stlpe_pkg::prim_hdr_t        push_hdr,
  input  logic [3*INDEX_BITS-1:0]     push_idx,
  input  logic                        pop,
  output stlpe_pkg::prim_hdr_t        head_hdr,
  output logic [3*INDEX_BITS-1:0]     head_idx,
  output stlpe_pkg::q_stat_t          q_stat
);
  import stlpe_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  prim_hdr_t             hdr_q [QUEUE_DEPTH];
  logic [3*INDEX_BITS-1:0] idx_q [QUEUE_DEPTH];

  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;

  assign q_stat.full  = (count_r == CNT_BITS'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head_hdr     = hdr_q[rd_ptr_r];
  assign head_idx     = idx_q[rd_ptr_r];

  // Wrap pointers at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the entry; payload needs no reset
  always_ff @(posedge clk) begin
    if (push) begin
      hdr_q[wr_ptr_r] <= push_hdr;
      idx_q[wr_ptr_r] <= push_idx;
    end
  end

endmodule

// ===== rtl/core/stlpe_back.sv =====
// ----------------------------------------------------------------------------
// stlpe_back
// Serialise queued primitives into one index per request on the result
// channel, through an output register.
// ----------------------------------------------------------------------------
module stlpe_back #(
  parameter int INDEX_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  stlpe_pkg::q_stat_t          q_stat,
  input  stlpe_pkg::prim_hdr_t        head_hdr,
  input  logic [3*INDEX_BITS-1:0]     head_idx,
  output logic                        pop,
  stlpe_out_if.source                 out_chan
);
  import stlpe_pkg::*;

  logic [1:0]            slot_r, slot_nxt;
  logic                  valid_r;
  logic [INDEX_BITS-1:0] index_r;
  logic                  end_r;
  prim_kind_t            kind_r;

  logic                  load;
  logic                  last;
  logic [INDEX_BITS-1:0] sel_index;

  // Load a new index when the output stage is free or drains
  assign load = !q_stat.empty && (!valid_r || out_chan.ready);
  assign last = (head_hdr.kind == PRIM_TRI) ? (slot_r == 2'd2) : (slot_r == 2'd1);
  assign pop  = load && last;

  // Pick the index of the current slot
  always_comb begin
    case (slot_r)
      2'd0:    sel_index = head_idx[INDEX_BITS-1:0];
      2'd1:    sel_index = head_idx[2*INDEX_BITS-1:INDEX_BITS];
      default: sel_index = head_idx[3*INDEX_BITS-1:2*INDEX_BITS];
    endcase
  end

  // Advance the slot, restart at each new primitive
  always_comb begin
    slot_nxt = slot_r;
    if (load) begin
      slot_nxt = last ? 2'd0 : slot_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      slot_r <= slot_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Hold the payload while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      index_r <= sel_index;
      end_r   <= last;
      kind_r  <= head_hdr.kind;
    end
  end

  assign out_chan.valid     = valid_r;
  assign out_chan.out_index = index_r;
  assign out_chan.prim_end  = end_r;
  assign out_chan.prim_kind = kind_r;

endmodule

// ===== rtl/core/strip_to_list_primitive_expander_unit.sv =====
// ----------------------------------------------------------------------------
// strip_to_list_primitive_expander_unit
// An accepted vertex's primitive is written into a two-entry queue that
// decouples front and back; its indices leave through the output register,
// one index per cycle while the receiver is ready. The single result port
// limits the vertex rate; new vertices are taken while the queue has room.
// Synchronous reset empties the queue and clears strip state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module strip_to_list_primitive_expander_unit #(
  parameter int INDEX_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  stlpe_in_if.sink    in_chan,
  stlpe_out_if.source out_chan
);
  import stlpe_pkg::*;

  logic                    push;
  logic                    pop;
  prim_hdr_t               push_hdr;
  prim_hdr_t               head_hdr;
  logic [3*INDEX_BITS-1:0] push_idx;
  logic [3*INDEX_BITS-1:0] head_idx;
  q_stat_t                 q_stat;

  // Classify vertices
  stlpe_front #(.INDEX_BITS(INDEX_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .q_stat   (q_stat),
    .push     (push),
    .push_hdr (push_hdr),
    .push_idx (push_idx)
  );

  // Buffer primitives
  stlpe_prim_queue #(.INDEX_BITS(INDEX_BITS)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_hdr (push_hdr),
    .push_idx (push_idx),
    .pop      (pop),
    .head_hdr (head_hdr),
    .head_idx (head_idx),
    .q_stat   (q_stat)
  );

  // Serialise indices
  stlpe_back #(.INDEX_BITS(INDEX_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .head_hdr (head_hdr),
    .head_idx (head_idx),
    .pop      (pop),
    .out_chan (out_chan)
  );

  // Checks on queue use and reset
  `ASSERT_IMP(a_no_push_full, clk, rst_n, push, !q_stat.full)
  `ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop, !q_stat.empty)
  `ASSERT_NXT(a_reset_clears, clk, !rst_n, q_stat.empty && !out_chan.valid)

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the strip-to-list primitive expander. Strip vertices are
// offered on the input channel, and every index on the result channel is
// checked against a local expansion of the same strips. A directed opening
// covers index wrapping, equal-index segments, skipped triangles, winding
// order and short strips. Random strips follow under several patterns of
// sender gaps and receiver stalls, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  import stlpe_pkg::*;

  localparam int IDX_W       = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_TAIL  = 8;
  localparam int PHASE_ITEMS = 75;

  typedef logic [IDX_W-1:0] index_t;

  // One strip vertex request
  typedef struct {
    strip_op_t op;
    logic      strip_start;
    index_t    vertex_index;
    index_t    index_base;
  } vertex_req_t;

  // One index of an emitted primitive
  typedef struct {
    index_t     idx;
    logic       last;
    prim_kind_t kind;
  } prim_index_t;

  logic clk;
  logic rst_n = 1'b0;

  stlpe_in_if  #(.INDEX_BITS(IDX_W)) in_chan ();
  stlpe_out_if #(.INDEX_BITS(IDX_W)) out_chan ();

  strip_to_list_primitive_expander_unit #(.INDEX_BITS(IDX_W)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  vertex_req_t vertex_queue[$];
  prim_index_t expected_indices[$];
  int          mismatches     = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  bit          vertex_taken   = 1'b0;
  bit          hold_off       = 1'b0;
  event        hold_go;

  // Strip state of the expansion
  index_t     older_idx;
  index_t     newer_idx;
  logic [1:0] strip_seen;
  logic       odd_position;
  strip_op_t  latched_kind;

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic queue_index(input index_t idx, input logic last, input prim_kind_t kind);
    prim_index_t p;
    p.idx  = idx;
    p.last = last;
    p.kind = kind;
    expected_indices.insert(expected_indices.size(), p);
  endtask

  // Expand one accepted vertex into the indices it releases
  task automatic expand_vertex(input vertex_req_t r);
    index_t v;
    v = r.vertex_index + r.index_base;
    if (r.strip_start) begin
      strip_seen   = '0;
      odd_position = 1'b0;
      latched_kind = r.op;
    end
    if (latched_kind == OP_LINE_STRIP) begin
      if (strip_seen != 2'd0 && newer_idx != v) begin
        queue_index(newer_idx, 1'b0, PRIM_LINE);
        queue_index(v, 1'b1, PRIM_LINE);
      end
    end else if (strip_seen == SEEN_FULL) begin
      if (older_idx != newer_idx && newer_idx != v && older_idx != v) begin
        if (odd_position) begin
          queue_index(newer_idx, 1'b0, PRIM_TRI);
          queue_index(older_idx, 1'b0, PRIM_TRI);
        end else begin
          queue_index(older_idx, 1'b0, PRIM_TRI);
          queue_index(newer_idx, 1'b0, PRIM_TRI);
        end
        queue_index(v, 1'b1, PRIM_TRI);
      end
      // winding follows the true strip position, skipped or not
      odd_position = !odd_position;
    end
    older_idx = newer_idx;
    newer_idx = v;
    if (strip_seen != SEEN_FULL) strip_seen = strip_seen + 2'd1;
  endtask

  task automatic add_vertex(input strip_op_t op, input logic start,
                            input index_t vidx, input index_t base);
    vertex_req_t r;
    r.op           = op;
    r.strip_start  = start;
    r.vertex_index = vidx;
    r.index_base   = base;
    vertex_queue.insert(vertex_queue.size(), r);
  endtask

  // Mostly well-formed strips with random content, some stray vertices
  task automatic add_random_strips(input int n_items);
    int        left;
    int        len;
    strip_op_t kind;
    index_t    base;
    index_t    vidx;
    index_t    vbase;
    left = n_items;
    while (left > 0) begin
      if ($urandom_range(9) == 0) begin
        add_vertex(strip_op_t'($urandom_range(1)), 1'($urandom_range(1)),
                   index_t'($urandom), index_t'($urandom));
        left--;
      end else begin
        kind = strip_op_t'($urandom_range(1));
        len  = $urandom_range(1, 8);
        if (len > left) len = left;
        base = ($urandom_range(3) == 0) ? '0 : index_t'($urandom);
        for (int k = 0; k < len; k++) begin
          // small offsets give repeats and hence dropped primitives
          vidx  = ($urandom_range(2) == 0) ? index_t'($urandom)
                                           : index_t'($urandom_range(7));
          vbase = ($urandom_range(7) == 0) ? index_t'($urandom) : base;
          if (k == 0) add_vertex(kind, 1'b1, vidx, vbase);
          else        add_vertex(strip_op_t'($urandom_range(1)), 1'b0, vidx, vbase);
        end
        left -= len;
      end
    end
  endtask

  task automatic wait_queue_empty();
    while (vertex_queue.size() != 0) @(posedge clk);
  endtask

  // Offer the head of the vertex queue, hold it until taken
  always @(negedge clk) begin : vertex_driver
    if (rst_n) begin
      if (vertex_taken) begin
        vertex_queue.delete(0);
        vertex_taken  = 1'b0;
        in_chan.valid = 1'b0;
      end
      if (!in_chan.valid && vertex_queue.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        in_chan.op           = vertex_queue[0].op;
        in_chan.strip_start  = vertex_queue[0].strip_start;
        in_chan.vertex_index = vertex_queue[0].vertex_index;
        in_chan.index_base   = vertex_queue[0].index_base;
        in_chan.valid        = 1'b1;
      end
    end
  end

  // Stall the result channel at random, or fully while held off
  always @(negedge clk) begin : result_receiver
    out_chan.ready = !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Long receiver hold-off, counted in cycles
  always begin : hold_off_timer
    @(hold_go);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // Predict on each accepted vertex, check each accepted index
  always @(posedge clk) begin : monitor
    vertex_req_t req;
    prim_index_t want;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        req.op           = strip_op_t'(in_chan.op);
        req.strip_start  = in_chan.strip_start;
        req.vertex_index = in_chan.vertex_index;
        req.index_base   = in_chan.index_base;
        expand_vertex(req);
        vertex_taken = 1'b1;
      end
      if (out_chan.valid && out_chan.ready) begin
        if (expected_indices.size() == 0) begin
          $display("%0t: unexpected index, expected none, got idx %h end %b kind %b",
                   $time, out_chan.out_index, out_chan.prim_end, out_chan.prim_kind);
          mismatches++;
        end else begin
          want = expected_indices.pop_front();
          if (out_chan.out_index !== want.idx) begin
            $display("%0t: out_index expected %h got %h",
                     $time, want.idx, out_chan.out_index);
            mismatches++;
          end
          if (out_chan.prim_end !== want.last) begin
            $display("%0t: prim_end expected %b got %b",
                     $time, want.last, out_chan.prim_end);
            mismatches++;
          end
          if (out_chan.prim_kind !== want.kind) begin
            $display("%0t: prim_kind expected %b got %b",
                     $time, want.kind, out_chan.prim_kind);
            mismatches++;
          end
        end
      end
    end
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // Stimulus and phases
  initial begin
    older_idx            = '0;
    newer_idx            = '0;
    strip_seen           = '0;
    odd_position         = 1'b0;
    latched_kind         = OP_LINE_STRIP;
    in_chan.valid        = 1'b0;
    in_chan.op           = 1'b0;
    in_chan.strip_start  = 1'b0;
    in_chan.vertex_index = '0;
    in_chan.index_base   = '0;
    out_chan.ready       = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // vertices before any strip start continue an empty line strip
    add_vertex(OP_LINE_STRIP, 1'b0, 16'd5, 16'd0);
    add_vertex(OP_LINE_STRIP, 1'b0, 16'd5, 16'd0);
    add_vertex(OP_TRI_STRIP,  1'b0, 16'd9, 16'd0);
    // rebasing wraps; equal-index segment dropped
    add_vertex(OP_LINE_STRIP, 1'b1, 16'hFFFF, 16'h0001);
    add_vertex(OP_LINE_STRIP, 1'b0, 16'hFFFF, 16'hFFFF);
    add_vertex(OP_LINE_STRIP, 1'b0, 16'h0000, 16'hFFFE);
    // triangle strip: even and odd winding, skipped triangles
    add_vertex(OP_TRI_STRIP,  1'b1, 16'd1, 16'h8000);
    add_vertex(OP_LINE_STRIP, 1'b0, 16'd2, 16'h8000);
    add_vertex(OP_LINE_STRIP, 1'b0, 16'd3, 16'h8000);
    add_vertex(OP_LINE_STRIP, 1'b0, 16'd4, 16'h8000);
    add_vertex(OP_LINE_STRIP, 1'b0, 16'd4, 16'h8000);
    add_vertex(OP_LINE_STRIP, 1'b0, 16'd5, 16'h8000);
    add_vertex(OP_LINE_STRIP, 1'b0, 16'd6, 16'h8000);
    add_vertex(OP_LINE_STRIP, 1'b0, 16'h7FFF, 16'h8000);
    add_vertex(OP_LINE_STRIP, 1'b0, 16'h8005, 16'h0000);
    add_vertex(OP_LINE_STRIP, 1'b0, 16'hFFFF, 16'h0000);
    // short strips: one-vertex line, one-vertex and two-vertex triangle
    add_vertex(OP_LINE_STRIP, 1'b1, 16'h1234, 16'h0000);
    add_vertex(OP_TRI_STRIP,  1'b1, 16'h0000, 16'h0000);
    add_vertex(OP_TRI_STRIP,  1'b1, 16'h0000, 16'h0000);
    add_vertex(OP_TRI_STRIP,  1'b0, 16'h0001, 16'h0000);
    // op without strip start keeps the latched line kind
    add_vertex(OP_LINE_STRIP, 1'b1, 16'd7, 16'd0);
    add_vertex(OP_TRI_STRIP,  1'b0, 16'd8, 16'd0);
    add_vertex(OP_LINE_STRIP, 1'b0, 16'hAAAA, 16'h5555);
    add_vertex(OP_LINE_STRIP, 1'b0, 16'h5555, 16'hAAAA);
    wait_queue_empty();

    add_random_strips(PHASE_ITEMS);
    wait_queue_empty();

    send_idle_pct  = 70;
    recv_stall_pct = 0;
    add_random_strips(PHASE_ITEMS);
    wait_queue_empty();

    send_idle_pct  = 0;
    recv_stall_pct = 70;
    add_random_strips(PHASE_ITEMS);
    wait_queue_empty();

    send_idle_pct  = 18;
    recv_stall_pct = 18;
    add_random_strips(PHASE_ITEMS);
    wait_queue_empty();

    // hold the receiver off while vertices keep coming
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    -> hold_go;
    add_random_strips(25);
    wait_queue_empty();

    while (expected_indices.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
